FILE: design/fenc_pkg.sv
// shared types, codes and constants of the fat entry next-cluster unit
`default_nettype none
package fenc_pkg;

    localparam int unsigned FAT_BYTES_MAX_DEF = 131072;

    // field widths fixed by the interface
    localparam int unsigned CLUS_W  = 28;
    localparam int unsigned SIZE_W  = 18;
    localparam int unsigned ADDR_W  = 17;
    localparam int unsigned LANES   = 4;

    // fat_type codes
    localparam logic [1:0] FT_FAT12   = 2'd0;
    localparam logic [1:0] FT_FAT16   = 2'd1;
    localparam logic [1:0] FT_FAT32   = 2'd2;
    localparam logic [1:0] FT_UNKNOWN = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOP_BITS = 2'd1;
    localparam logic [1:0] ST_BEYOND   = 2'd2;
    localparam logic [1:0] ST_BAD_TYPE = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_FAT_TYPE    = 2'd0;
    localparam logic [1:0] CFG_FAT_SIZE    = 2'd1;
    localparam logic [1:0] CFG_MAX_CLUSTER = 2'd2;

    localparam logic [31:0] CLUS_TOP_MASK = 32'hf000_0000;
    localparam logic [31:0] FAT32_MASK    = 32'h0fff_ffff;
    localparam logic [15:0] FAT12_MASK    = 16'h0fff;
    localparam logic [27:0] EOC_FAT12     = 28'h0000ff7;
    localparam logic [27:0] EOC_FAT16     = 28'h000fff7;
    localparam logic [27:0] EOC_FAT32     = 28'hffffff7;

    localparam logic [27:0] MAX_CLUSTER_RST = 28'd2;

    // lookup context carried alongside the store read
    typedef struct packed {
        logic [1:0] status;
        logic [1:0] lane_sel;   // lane holding the entry's first byte
        logic       odd;        // cluster number is odd
    } t_lookup_info;

    // decoded lookup result
    typedef struct packed {
        logic [1:0]        status;
        logic              next_is_data;
        logic              end_of_chain;
        logic [CLUS_W-1:0] next_cluster;
    } t_fenc_result;

endpackage
`default_nettype wire

FILE: design/fenc_lane_ram.sv
// one byte lane of the fat image store, registered read
`default_nettype none
module fenc_lane_ram #(
    parameter int unsigned DEPTH = 32768,
    parameter int unsigned AW    = 15
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: design/fenc_addr_gen.sv
// entry offset, bound and type checks, and per-lane row addresses of a lookup
`default_nettype none
module fenc_addr_gen #(
    parameter int unsigned FAT_BYTES_MAX = fenc_pkg::FAT_BYTES_MAX_DEF,
    parameter int unsigned RW            = 15
) (
    input  wire logic [31:0]                   i_cluster,
    input  wire logic [1:0]                    i_fat_type,
    input  wire logic [fenc_pkg::SIZE_W-1:0]   i_fat_size,
    output fenc_pkg::t_lookup_info             o_info,
    output logic [fenc_pkg::LANES-1:0][RW-1:0] o_row
);

    localparam logic [31:0] MAX32 = 32'(FAT_BYTES_MAX);

    logic [31:0]   w_c;
    logic [31:0]   w_off;
    logic [31:0]   w_end;
    logic [31:0]   w_limit;
    logic [31:0]   w_size;
    logic [RW-1:0] w_row_base;

    assign w_c    = {4'd0, i_cluster[27:0]};
    assign w_size = {{(32-fenc_pkg::SIZE_W){1'b0}}, i_fat_size};

    always_comb begin
        unique case (i_fat_type)
            fenc_pkg::FT_FAT12: begin
                w_off = w_c + {1'b0, w_c[31:1]};
                w_end = w_off + 32'd2;
            end
            fenc_pkg::FT_FAT16: begin
                w_off = {w_c[30:0], 1'b0};
                w_end = w_off + 32'd2;
            end
            default: begin
                w_off = {w_c[29:0], 2'b00};
                w_end = w_off + 32'd4;
            end
        endcase
    end

    assign w_limit    = (w_size > MAX32) ? MAX32 : w_size;
    assign w_row_base = w_off[RW+1:2];

    // lanes below the start lane hold bytes of the following row
    always_comb begin
        for (int l = 0; l < fenc_pkg::LANES; l++) begin
            o_row[l] = w_row_base + RW'(((2'(l)) < w_off[1:0]) ? 1 : 0);
        end
    end

    // checks in order: top bits, unknown type, size
    always_comb begin
        o_info.lane_sel = w_off[1:0];
        o_info.odd      = i_cluster[0];
        if ((i_cluster & fenc_pkg::CLUS_TOP_MASK) != 32'd0) begin
            o_info.status = fenc_pkg::ST_TOP_BITS;
        end else if (i_fat_type == fenc_pkg::FT_UNKNOWN) begin
            o_info.status = fenc_pkg::ST_BAD_TYPE;
        end else if (w_end > w_limit) begin
            o_info.status = fenc_pkg::ST_BEYOND;
        end else begin
            o_info.status = fenc_pkg::ST_OK;
        end
    end

endmodule
`default_nettype wire

FILE: design/fenc_entry_decode.sv
// byte alignment and decode of a fat entry into the next-cluster result
`default_nettype none
module fenc_entry_decode (
    input  wire logic [fenc_pkg::LANES-1:0][7:0] i_lane_data,
    input  wire fenc_pkg::t_lookup_info          i_info,
    input  wire logic [1:0]                      i_fat_type,
    input  wire logic [fenc_pkg::CLUS_W-1:0]     i_max_cluster,
    output fenc_pkg::t_fenc_result               o_result
);

    logic [3:0][7:0]              w_byte;
    logic [31:0]                  w_raw;
    logic [fenc_pkg::CLUS_W-1:0]  w_val;
    logic [fenc_pkg::CLUS_W-1:0]  w_thresh;

    // rotate lanes so byte 0 is the entry's first byte
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_byte[k] = i_lane_data[i_info.lane_sel + 2'(k)];
        end
    end

    assign w_raw = w_byte;

    always_comb begin
        unique case (i_fat_type)
            fenc_pkg::FT_FAT12: begin
                w_val    = i_info.odd ? 28'({4'd0, w_raw[15:4]})
                                      : 28'(w_raw[15:0] & fenc_pkg::FAT12_MASK);
                w_thresh = fenc_pkg::EOC_FAT12;
            end
            fenc_pkg::FT_FAT16: begin
                w_val    = 28'(w_raw[15:0]);
                w_thresh = fenc_pkg::EOC_FAT16;
            end
            default: begin
                w_val    = 28'(w_raw & fenc_pkg::FAT32_MASK);
                w_thresh = fenc_pkg::EOC_FAT32;
            end
        endcase
    end

    always_comb begin
        o_result.status = i_info.status;
        if (i_info.status == fenc_pkg::ST_OK) begin
            o_result.next_cluster = w_val;
            o_result.end_of_chain = (w_val > w_thresh);
            o_result.next_is_data = (w_val >= 28'd2) && (w_val <= i_max_cluster);
        end else begin
            o_result.next_cluster = '0;
            o_result.end_of_chain = 1'b0;
            o_result.next_is_data = 1'b0;
        end
    end

endmodule
`default_nettype wire

FILE: design/fat_entry_next_cluster_unit.sv
// top level: fat image byte store with next-cluster lookup pipeline
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser kind, tdata addr/byte/cluster
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata next/eoc/data/status
// cfg       in   i_cfg_we (no wait)             i_cfg_idx, i_cfg_wdata
//
// one request per cycle while s_axis_tready is high; a lookup reads all four byte
// lanes in the cycle after acceptance; its result is registered once output frees
// four lane memories, one read port each: one entry per cycle unless stalled
// a load writes one lane and gives no result; loads at or past FAT_BYTES_MAX drop
// reset clears only control and configuration; the store needs no clearing pass
// a stalled result holds the read stage; the input takes a request while it is free
`default_nettype none
module fat_entry_next_cluster_unit #(
    parameter int unsigned FAT_BYTES_MAX = fenc_pkg::FAT_BYTES_MAX_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // byte_addr[16:0], byte_value[24:17],
                                             // cluster[56:25], zero fill
    input  wire logic        s_axis_tuser,   // kind: 0 load, 1 lookup
    // result out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // next_cluster[27:0], end_of_chain[28],
                                             // next_is_data[29], status[31:30]
    // configuration writes
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [27:0] i_cfg_wdata
);

    localparam int unsigned DEPTH = (FAT_BYTES_MAX + 3) / 4;
    localparam int unsigned RW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [31:0] MAX32 = 32'(FAT_BYTES_MAX);
    localparam int unsigned LANES = fenc_pkg::LANES;

    // configuration registers
    logic [1:0]                  r_fat_type;
    logic [fenc_pkg::SIZE_W-1:0] r_fat_size;
    logic [fenc_pkg::CLUS_W-1:0] r_max_cluster;

    // request fields
    logic        w_kind;
    logic [31:0] w_byte_addr;
    logic [7:0]  w_byte_value;
    logic [31:0] w_cluster;

    // pipeline control
    logic w_accept;
    logic w_advance;
    logic w_s1_free;
    logic w_load_we;
    logic w_lookup_re;

    logic                    r_s1_valid;
    fenc_pkg::t_lookup_info  r_s1_info;
    fenc_pkg::t_lookup_info  w_info;
    logic                    r_out_valid;
    fenc_pkg::t_fenc_result  r_out;
    fenc_pkg::t_fenc_result  w_result;

    logic [LANES-1:0][RW-1:0] w_row;
    logic [LANES-1:0][7:0]    w_lane_data;

    assign w_kind       = s_axis_tuser;
    assign w_byte_addr  = {15'd0, s_axis_tdata[16:0]};
    assign w_byte_value = s_axis_tdata[24:17];
    assign w_cluster    = s_axis_tdata[56:25];

    // output register frees when empty or taken; read stage frees when it moves on
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_s1_free     = !r_s1_valid || w_advance;
    assign s_axis_tready = w_s1_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_load_we     = w_accept && !w_kind && (w_byte_addr < MAX32);
    assign w_lookup_re   = w_accept && w_kind;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fat_type    <= fenc_pkg::FT_FAT12;
            r_fat_size    <= '0;
            r_max_cluster <= fenc_pkg::MAX_CLUSTER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fenc_pkg::CFG_FAT_TYPE:    r_fat_type    <= i_cfg_wdata[1:0];
                fenc_pkg::CFG_FAT_SIZE:    r_fat_size    <= i_cfg_wdata[fenc_pkg::SIZE_W-1:0];
                fenc_pkg::CFG_MAX_CLUSTER: r_max_cluster <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    fenc_addr_gen #(
        .FAT_BYTES_MAX (FAT_BYTES_MAX),
        .RW            (RW)
    ) u_addr_gen (
        .i_cluster  (w_cluster),
        .i_fat_type (r_fat_type),
        .i_fat_size (r_fat_size),
        .o_info     (w_info),
        .o_row      (w_row)
    );

    // four byte lanes: byte address a lives in lane a[1:0], row a>>2
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic w_we;
        assign w_we = w_load_we && (w_byte_addr[1:0] == 2'(l));

        fenc_lane_ram #(
            .DEPTH (DEPTH),
            .AW    (RW)
        ) u_lane_ram (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (w_byte_addr[RW+1:2]),
            .i_wdata (w_byte_value),
            .i_re    (w_lookup_re),
            .i_raddr (w_row[l]),
            .o_rdata (w_lane_data[l])
        );
    end

    // read stage: lookup context waits beside the store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_valid <= w_lookup_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_lookup_re) begin
            r_s1_info <= w_info;
        end
    end

    fenc_entry_decode u_entry_decode (
        .i_lane_data   (w_lane_data),
        .i_info        (r_s1_info),
        .i_fat_type    (r_fat_type),
        .i_max_cluster (r_max_cluster),
        .o_result      (w_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_s1_valid) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule
`default_nettype wire
